>>> design/scl_pkg.sv
// Shared types and constants for the supply command line parser.
// Holds the action and letter codes, character constants and the result struct.
// No dependencies.
package scl_pkg;

  // Default sizing of the line decoder
  localparam int MaxLineDefault     = 32;
  localparam int NumberStartDefault = 6;
  localparam int NumberCharsDefault = 6;

  // A line must be longer than this to carry a command
  localparam int MinLenExcl = 6;

  localparam int ValueW = 16;
  localparam int CharW  = 8;

  // Characters the decoder looks for
  localparam logic [CharW-1:0] ChS     = 8'h73;  // 's'
  localparam logic [CharW-1:0] ChG     = 8'h67;  // 'g'
  localparam logic [CharW-1:0] ChE     = 8'h65;  // 'e'
  localparam logic [CharW-1:0] ChT     = 8'h74;  // 't'
  localparam logic [CharW-1:0] ChA     = 8'h61;  // 'a'
  localparam logic [CharW-1:0] ChV     = 8'h76;  // 'v'
  localparam logic [CharW-1:0] ChSpace = 8'h20;  // ' '
  localparam logic [CharW-1:0] ChZero  = 8'h30;  // '0'
  localparam logic [CharW-1:0] ChNine  = 8'h39;  // '9'
  localparam logic [CharW-1:0] ChNul   = 8'h00;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_SET_A = 3'd1,
    ACT_SET_V = 3'd2,
    ACT_GET_A = 3'd3,
    ACT_GET_V = 3'd4,
    ACT_HELP  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    LEAD_OTHER = 2'd0,
    LEAD_S     = 2'd1,
    LEAD_G     = 2'd2
  } lead_t;

  typedef enum logic [1:0] {
    TGT_OTHER = 2'd0,
    TGT_A     = 2'd1,
    TGT_V     = 2'd2
  } target_t;

  typedef struct packed {
    action_t             action;
    logic [ValueW-1:0]   set_value;
  } scl_result_t;

endpackage

>>> design/scl_line_dec.sv
// Per-line state of the command parser and the decode of a finished line.
// Updates the state once per stepped character and decodes on the last one.
// Depends on scl_pkg.
module scl_line_dec #(
  parameter int MAX_LINE     = scl_pkg::MaxLineDefault,
  parameter int NUMBER_START = scl_pkg::NumberStartDefault,
  parameter int NUMBER_CHARS = scl_pkg::NumberCharsDefault
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [scl_pkg::CharW-1:0] line_char,
  input  logic                      end_of_line,
  output scl_pkg::scl_result_t      result
);
  import scl_pkg::*;

  localparam int PosW = $clog2(MAX_LINE + 1);

  logic [PosW-1:0]   pos_r, pos_nxt;
  lead_t             lead_r, lead_nxt;
  logic              kw_r, kw_nxt;
  target_t           tgt_r, tgt_nxt;
  logic              num_valid_r, num_valid_nxt;
  logic [ValueW-1:0] acc_r, acc_nxt;
  logic              ended_r, ended_nxt;

  logic              is_digit;
  logic [ValueW-1:0] digit;
  logic [ValueW-1:0] acc_x10;
  action_t           action;
  logic [ValueW-1:0] value;

  assign is_digit = (line_char >= ChZero) && (line_char <= ChNine);
  assign digit    = {{(ValueW-CharW){1'b0}}, line_char} - {{(ValueW-CharW){1'b0}}, ChZero};
  assign acc_x10  = (acc_r << 3) + (acc_r << 1);

  // Fold the current character into the line state
  always_comb begin
    pos_nxt       = pos_r;
    lead_nxt      = lead_r;
    kw_nxt        = kw_r;
    tgt_nxt       = tgt_r;
    num_valid_nxt = num_valid_r;
    acc_nxt       = acc_r;
    ended_nxt     = ended_r;
    if (!ended_r) begin
      if (line_char == ChNul) begin
        ended_nxt = 1'b1;
      end else begin
        if (pos_r == PosW'(0)) begin
          lead_nxt = (line_char == ChS) ? LEAD_S : (line_char == ChG) ? LEAD_G : LEAD_OTHER;
        end else if (pos_r == PosW'(1)) begin
          if (line_char != ChE) kw_nxt = 1'b0;
        end else if (pos_r == PosW'(2)) begin
          if (line_char != ChT) kw_nxt = 1'b0;
        end else if (pos_r == PosW'(3)) begin
          if (line_char != ChSpace) kw_nxt = 1'b0;
        end else if (pos_r == PosW'(4)) begin
          tgt_nxt = (line_char == ChA) ? TGT_A : (line_char == ChV) ? TGT_V : TGT_OTHER;
        end
        if (32'(pos_r) == NUMBER_START) begin
          if (is_digit) begin
            num_valid_nxt = 1'b1;
            acc_nxt       = digit;
          end
        end else if (num_valid_r && (32'(pos_r) > NUMBER_START) &&
                     (32'(pos_r) < NUMBER_START + NUMBER_CHARS)) begin
          acc_nxt = acc_x10 + digit;
        end
        if (32'(pos_r) < MAX_LINE) pos_nxt = pos_r + PosW'(1);
      end
    end
  end

  // Decode the line as it stands after this character
  always_comb begin
    action = ACT_NONE;
    if (32'(pos_nxt) > MinLenExcl) begin
      unique case (lead_nxt)
        LEAD_S: begin
          if (kw_nxt) begin
            action = (tgt_nxt == TGT_A) ? ACT_SET_A :
                     (tgt_nxt == TGT_V) ? ACT_SET_V : ACT_HELP;
          end
        end
        LEAD_G: begin
          if (kw_nxt) begin
            action = (tgt_nxt == TGT_A) ? ACT_GET_A :
                     (tgt_nxt == TGT_V) ? ACT_GET_V : ACT_NONE;
          end
        end
        default: action = ACT_HELP;
      endcase
    end
    value = '0;
    if ((action == ACT_SET_A || action == ACT_SET_V) && num_valid_nxt &&
        (32'(pos_nxt) < MAX_LINE)) begin
      value = acc_nxt;
    end
  end

  assign result.action    = action;
  assign result.set_value = value;

  // Advance the state; clear it for the next line after the last character
  always_ff @(posedge clk) begin
    if (!rst_n || (step && end_of_line)) begin
      pos_r       <= '0;
      lead_r      <= LEAD_OTHER;
      kw_r        <= 1'b1;
      tgt_r       <= TGT_OTHER;
      num_valid_r <= 1'b0;
      acc_r       <= '0;
      ended_r     <= 1'b0;
    end else if (step) begin
      pos_r       <= pos_nxt;
      lead_r      <= lead_nxt;
      kw_r        <= kw_nxt;
      tgt_r       <= tgt_nxt;
      num_valid_r <= num_valid_nxt;
      acc_r       <= acc_nxt;
      ended_r     <= ended_nxt;
    end
  end

  // Length never runs past its saturation point
  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pos_r) <= MAX_LINE)
    else $error("line length above saturation");

  // A finished line leaves the state cleared
  a_clear_after_line: assert property (@(posedge clk) disable iff (!rst_n)
    step && end_of_line |=> pos_r == '0 && !ended_r && !num_valid_r && kw_r)
    else $error("line state not cleared after last character");

  // A number is folded only once its first digit has been seen
  a_acc_needs_digit: assert property (@(posedge clk) disable iff (!rst_n)
    !num_valid_r |-> acc_r == '0)
    else $error("number folded without a leading digit");

endmodule

>>> design/supply_command_line_parser.sv
// Supply command line parser: one character per transfer in, one command per line out.
// The result of a line appears on out_ once its last character has passed the input
// register and then the result register. Throughput: one character per cycle, set by the
// line decoder's state update; out_ back-pressure stalls in_ only on a last character.
// Reset (rst_n low, synchronous) empties both registers and clears the line state.
// Depends on scl_pkg and scl_line_dec.
module supply_command_line_parser #(
  parameter int MAX_LINE     = scl_pkg::MaxLineDefault,
  parameter int NUMBER_START = scl_pkg::NumberStartDefault,
  parameter int NUMBER_CHARS = scl_pkg::NumberCharsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] line_char
  input  logic        in_tlast,   // end_of_line
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [2:0] action, [18:3] set_value, [23:19] zero
);
  import scl_pkg::*;

  logic             s1_valid_r;
  logic [CharW-1:0] s1_char_r;
  logic             s1_last_r;
  logic             s1_adv;
  logic             out_free;
  logic             out_load;
  scl_result_t      dec_result;
  scl_result_t      out_r;
  logic             out_valid_r;

  // A last character needs room in the result register; others pass freely
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!s1_last_r || out_free);
  assign out_load  = s1_adv && s1_last_r;
  assign in_tready = !s1_valid_r || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_char_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  scl_line_dec #(
    .MAX_LINE     (MAX_LINE),
    .NUMBER_START (NUMBER_START),
    .NUMBER_CHARS (NUMBER_CHARS)
  ) u_line_dec (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_adv),
    .line_char   (s1_char_r),
    .end_of_line (s1_last_r),
    .result      (dec_result)
  );

  // Result register: hold until the downstream transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_r <= dec_result;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_r.set_value, out_r.action};

  // Only the last character of a line produces a result
  a_load_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> s1_valid_r && s1_last_r)
    else $error("result loaded for a character that is not last");

  // Value is carried only by set commands
  a_value_only_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.action != ACT_SET_A && out_r.action != ACT_SET_V
      |-> out_r.set_value == '0)
    else $error("non-set command carries a value");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !out_load)
    else $error("pending result overwritten");

endmodule

>>> tb/supply_command_line_parser_tb.sv
// Self-checking testbench for supply_command_line_parser: text lines go in one character
// per transfer; each command is checked against a typed-in result or a line decoder here.
// Depends on scl_pkg and the RTL of supply_command_line_parser.
module supply_command_line_parser_tb;
  import scl_pkg::*;

  localparam int RandomChars = 1400;
  localparam int CalmFrom    = 1250;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 8;

  // One line of the directed table: text right-justified in 'text', then 'pad' nines
  typedef struct packed {
    logic [127:0] text;
    logic [4:0]   len;
    logic [5:0]   pad;
    logic         typed;
    scl_result_t  want;
  } cmd_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] line_char
  logic        in_tlast = 1'b0; // end_of_line
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [2:0] action, [18:3] set_value, [23:19] zero

  // Line decoder state, cleared after every line
  logic [5:0]  ln_pos = '0;
  lead_t       ln_lead = LEAD_OTHER;
  logic        ln_kw_ok = 1'b1;
  target_t     ln_target = TGT_OTHER;
  logic        ln_num_ok = 1'b0;
  logic [15:0] ln_num = '0;
  logic        ln_ended = 1'b0;

  // Typed-in result for the directed row being sent, used instead of the decoder's
  logic        row_typed = 1'b0;
  scl_result_t row_result;

  scl_result_t cmd_expected[$];
  int          errors = 0;
  int          chars_sent = 0;
  logic        calm = 1'b0;
  logic        quiet_line = 1'b0;

  supply_command_line_parser u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Advance the line decoder by one accepted character; queue the command at end of line
  task automatic parse_char(input logic [7:0] c, input logic eol);
    scl_result_t res;
    if (!ln_ended) begin
      if (c == ChNul) begin
        ln_ended = 1'b1;
      end else begin
        case (ln_pos)
          6'd0: ln_lead = (c == ChS) ? LEAD_S : (c == ChG) ? LEAD_G : LEAD_OTHER;
          6'd1: if (c != ChE) ln_kw_ok = 1'b0;
          6'd2: if (c != ChT) ln_kw_ok = 1'b0;
          6'd3: if (c != ChSpace) ln_kw_ok = 1'b0;
          6'd4: ln_target = (c == ChA) ? TGT_A : (c == ChV) ? TGT_V : TGT_OTHER;
          default: ;
        endcase
        // Fold the number; later characters need not be digits
        if (ln_pos == NumberStartDefault) begin
          if (c >= ChZero && c <= ChNine) begin
            ln_num_ok = 1'b1;
            ln_num = {8'h00, c - ChZero};
          end
        end else if (ln_num_ok && ln_pos > NumberStartDefault &&
                     ln_pos < NumberStartDefault + NumberCharsDefault) begin
          ln_num = ln_num * 16'd10 + {8'h00, c} - {8'h00, ChZero};
        end
        if (ln_pos < MaxLineDefault) ln_pos = ln_pos + 6'd1;
      end
    end
    if (eol) begin
      res.action = ACT_NONE;
      res.set_value = '0;
      if (ln_pos > MinLenExcl) begin
        case (ln_lead)
          LEAD_S: begin
            if (ln_kw_ok) begin
              if (ln_target == TGT_A) res.action = ACT_SET_A;
              else if (ln_target == TGT_V) res.action = ACT_SET_V;
              else res.action = ACT_HELP;
            end
          end
          LEAD_G: begin
            if (ln_kw_ok) begin
              if (ln_target == TGT_A) res.action = ACT_GET_A;
              else if (ln_target == TGT_V) res.action = ACT_GET_V;
            end
          end
          default: res.action = ACT_HELP;
        endcase
      end
      if ((res.action == ACT_SET_A || res.action == ACT_SET_V) && ln_num_ok &&
          ln_pos < MaxLineDefault) begin
        res.set_value = ln_num;
      end
      cmd_expected.push_back(row_typed ? row_result : res);
      ln_pos = '0;
      ln_lead = LEAD_OTHER;
      ln_kw_ok = 1'b1;
      ln_target = TGT_OTHER;
      ln_num_ok = 1'b0;
      ln_num = '0;
      ln_ended = 1'b0;
    end
  endtask

  // Present one character, at times after a random gap, and hold it until the transfer
  task automatic send_char(input logic [7:0] c, input logic eol);
    if (!calm && !quiet_line && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= eol;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_char(c, eol);
    chars_sent++;
  endtask

  // Stop sending until every queued command has come out
  task automatic drain_commands();
    in_tvalid <= 1'b0;
    while (cmd_expected.size() != 0) @(posedge clk);
  endtask

  function automatic cmd_row_t dir_row(input logic [127:0] text, input int len, input int pad,
                                       input logic typed, input action_t act,
                                       input logic [15:0] val);
    cmd_row_t r;
    r.text = text;
    r.len = len[4:0];
    r.pad = pad[5:0];
    r.typed = typed;
    r.want.action = act;
    r.want.set_value = val;
    return r;
  endfunction

  // Compare one command transfer with the oldest expectation
  task automatic check_command(input logic [23:0] d);
    scl_result_t want;
    if (cmd_expected.size() == 0) begin
      $display("%0t: unexpected command, expected none, got action %0d value %0d",
               $time, d[2:0], d[18:3]);
      errors++;
    end else begin
      want = cmd_expected.pop_front();
      if (d[2:0] != want.action) begin
        $display("%0t: action mismatch, expected %0d, got %0d", $time, want.action, d[2:0]);
        errors++;
      end
      if (d[18:3] != want.set_value) begin
        $display("%0t: set_value mismatch, expected %0d, got %0d",
                 $time, want.set_value, d[18:3]);
        errors++;
      end
      if (d[23:19] != '0) begin
        $display("%0t: padding mismatch, expected 0, got %0h", $time, d[23:19]);
        errors++;
      end
    end
  endtask

  // Result side: check each transfer, stall in random bursts
  initial begin
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) check_command(out_tdata);
      if (stall_left == 0 && run_left == 0) begin
        if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 13);
        else run_left = $urandom_range(1, 24);
      end
      if (calm || stall_left == 0) begin
        out_tready <= 1'b1;
        if (run_left > 0) run_left--;
      end else begin
        out_tready <= 1'b0;
        stall_left--;
      end
    end
  end

  // Timeout
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("supply_command_line_parser verification failed");
    $finish;
  end

  // Stimulus
  initial begin
    cmd_row_t    dir_rows[$];
    cmd_row_t    row;
    logic [7:0]  line_q[$];
    int          kind;
    int          n;
    logic        paused;

    dir_rows.push_back(dir_row("x", 1, 0, 1'b1, ACT_NONE, 16'd0));
    dir_rows.push_back(dir_row("set a 1234567", 13, 0, 1'b0, ACT_NONE, 16'd0));
    dir_rows.push_back(dir_row("set v 65535", 11, 0, 1'b1, ACT_SET_V, 16'd65535));
    dir_rows.push_back(dir_row("set a 0", 7, 0, 1'b1, ACT_SET_A, 16'd0));
    dir_rows.push_back(dir_row("get a  ", 7, 0, 1'b1, ACT_GET_A, 16'd0));
    dir_rows.push_back(dir_row("get v 99", 8, 0, 1'b1, ACT_GET_V, 16'd0));
    dir_rows.push_back(dir_row("set x 12", 8, 0, 1'b1, ACT_HELP, 16'd0));
    dir_rows.push_back(dir_row("get x 12", 8, 0, 1'b1, ACT_NONE, 16'd0));
    dir_rows.push_back(dir_row("sex a 12", 8, 0, 1'b1, ACT_NONE, 16'd0));
    dir_rows.push_back(dir_row("hello world", 11, 0, 1'b1, ACT_HELP, 16'd0));
    dir_rows.push_back(dir_row("set a", 5, 0, 1'b1, ACT_NONE, 16'd0));
    dir_rows.push_back(dir_row("set a ", 6, 0, 1'b1, ACT_NONE, 16'd0));
    dir_rows.push_back(dir_row("set a x12", 9, 0, 1'b1, ACT_SET_A, 16'd0));
    // zero byte ends the text: only "set v 4" counts
    dir_rows.push_back(dir_row({"set v 4", 8'h00, "999"}, 11, 0, 1'b1, ACT_SET_V, 16'd4));
    dir_rows.push_back(dir_row({8'h00, "set a 5"}, 8, 0, 1'b1, ACT_NONE, 16'd0));
    dir_rows.push_back(dir_row({"get v 1", 8'h00}, 8, 0, 1'b1, ACT_GET_V, 16'd0));
    // overlong line drops the value; one short of the limit keeps it
    dir_rows.push_back(dir_row("set a 12", 8, 30, 1'b1, ACT_SET_A, 16'd0));
    dir_rows.push_back(dir_row("set v 1", 7, 24, 1'b0, ACT_NONE, 16'd0));
    dir_rows.push_back(dir_row({8'hff, "et a 7", 8'hff}, 8, 0, 1'b0, ACT_NONE, 16'd0));
    dir_rows.push_back(dir_row("set a 9:;<=>", 12, 0, 1'b0, ACT_NONE, 16'd0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines
    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      row_typed = row.typed;
      row_result = row.want;
      quiet_line = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < row.len; i++) begin
        send_char(row.text[8*(row.len-1-i) +: 8], row.pad == 0 && i == row.len - 1);
      end
      for (int i = 0; i < row.pad; i++) send_char(ChNine, i == row.pad - 1);
    end
    row_typed = 1'b0;
    drain_commands();

    // Random lines, mostly well formed commands with random content
    chars_sent = 0;
    paused = 1'b0;
    while (chars_sent < RandomChars) begin
      line_q.delete();
      kind = $urandom_range(0, 9);
      if (kind == 6) begin
        n = $urandom_range(1, 12);
        repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        line_q.push_back($urandom_range(0, 1) ? ChS : ChG);
        line_q.push_back(ChE);
        line_q.push_back(ChT);
        line_q.push_back(ChSpace);
        n = $urandom_range(0, 7);
        line_q.push_back(n < 3 ? ChA : n < 6 ? ChV : 8'($urandom_range(0, 255)));
        line_q.push_back(ChSpace);
        n = $urandom_range(0, 8);
        repeat (n) line_q.push_back(8'(ChZero + $urandom_range(0, 9)));
        if ($urandom_range(0, 3) == 0) begin
          n = $urandom_range(1, 4);
          repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 5) == 0) begin
          line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
        end
        if (kind == 7) begin
          n = $urandom_range(18, 30);
          repeat (n) line_q.push_back(8'($urandom_range(8'h21, 8'h7e)));
        end else if (kind == 8) begin
          n = $urandom_range(1, 7);
          while (line_q.size() > n) line_q.pop_back();
        end else if (kind == 9) begin
          line_q.insert($urandom_range(0, line_q.size()), ChNul);
        end
      end
      calm = (chars_sent >= CalmFrom);
      quiet_line = ($urandom_range(0, 3) == 0);
      foreach (line_q[i]) send_char(line_q[i], i == line_q.size() - 1);
      // Hold off once midway until the block is empty
      if (!paused && chars_sent >= RandomChars / 2) begin
        paused = 1'b1;
        drain_commands();
      end
    end

    // Wait for the last commands, then let the pipeline settle
    in_tvalid <= 1'b0;
    while (cmd_expected.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("supply_command_line_parser verification clean");
    end else begin
      $display("supply_command_line_parser verification failed");
    end
    $finish;
  end

endmodule
